[rtl/core/tcw_pkg.sv]
// Shared types and constants of the text console writer.
// No dependencies; every other file refers to this one by scoped names.
package tcw_pkg;

   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int NUMBER_W = 32;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int ADDR_W   = 11;
   localparam int WORD_W   = 16;
   localparam int ATTR_W   = 8;

   localparam int DIGITS   = 10;
   localparam int DIGIT_W  = 4;
   localparam int BCD_W    = DIGITS * DIGIT_W;
   localparam int LEFT_W   = 4;

   localparam logic [ACTION_W-1:0] ACT_PUT_CHAR   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PRINT_NUM  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SET_CURSOR = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;

   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // digit stream from the decimal converter to the cursor engine
   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } bcd_status_type;

endpackage

[rtl/core/tcw_if.sv]
// Handshake channels of the text console writer: request, response, register write.
// Depends on tcw_pkg for field widths.
interface tcw_req_if;
   logic                                valid;
   logic                                ready;
   logic [tcw_pkg::ACTION_W-1:0]        action;
   logic [tcw_pkg::CHAR_W-1:0]          char_code;
   logic signed [tcw_pkg::NUMBER_W-1:0] number_value;
   logic [tcw_pkg::COL_W-1:0]           new_column;
   logic [tcw_pkg::ROW_W-1:0]           new_row;

   modport source (output valid, action, char_code, number_value, new_column, new_row,
                   input ready);
   modport sink   (input valid, action, char_code, number_value, new_column, new_row,
                   output ready);
endinterface

interface tcw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         result_kind;
   logic [tcw_pkg::ADDR_W-1:0]   cell_address;
   logic [tcw_pkg::WORD_W-1:0]   cell_word;
   logic                         last_result;

   modport source (output valid, result_kind, cell_address, cell_word, last_result,
                   input ready);
   modport sink   (input valid, result_kind, cell_address, cell_word, last_result,
                   output ready);
endinterface

interface tcw_csr_if;
   logic                       valid;
   logic                       ready;
   logic [tcw_pkg::ATTR_W-1:0] color_attribute;

   modport source (output valid, color_attribute, input ready);
   modport sink   (input valid, color_attribute, output ready);
endinterface

[rtl/core/tcw_bcd.sv]
// Iterative binary to decimal converter (shift and add-3, one bit per cycle),
// then a digit stream with leading zeros dropped. Depends on tcw_pkg.
module tcw_bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tcw_pkg::NUMBER_W-1:0]  bin,
   input  logic                          next,
   output tcw_pkg::bcd_status_type       status
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CONV = 2'd1;
   localparam logic [1:0] PH_SKIP = 2'd2;
   localparam logic [1:0] PH_OUT  = 2'd3;

   localparam int STEP_W = $clog2(tcw_pkg::NUMBER_W);

   logic [1:0]                     phase_ff, phase_in;
   logic [tcw_pkg::NUMBER_W-1:0]   bin_ff, bin_in;
   logic [tcw_pkg::BCD_W-1:0]      bcd_ff, bcd_in;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic [tcw_pkg::LEFT_W-1:0]     left_ff, left_in;
   logic [tcw_pkg::BCD_W-1:0]      adj;
   logic [tcw_pkg::DIGIT_W-1:0]    top_digit;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      logic [tcw_pkg::DIGIT_W-1:0] d;
      adj = '0;
      for (int i = 0; i < tcw_pkg::DIGITS; i++) begin
         d = bcd_ff[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W];
         adj[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
      end
   end

   assign top_digit = bcd_ff[tcw_pkg::BCD_W-1 -: tcw_pkg::DIGIT_W];

   always_comb begin
      phase_in = phase_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               bin_in   = bin;
               bcd_in   = '0;
               step_in  = STEP_W'(tcw_pkg::NUMBER_W - 1);
               left_in  = tcw_pkg::LEFT_W'(tcw_pkg::DIGITS);
               phase_in = PH_CONV;
            end
         end
         PH_CONV: begin
            bcd_in  = {adj[tcw_pkg::BCD_W-2:0], bin_ff[tcw_pkg::NUMBER_W-1]};
            bin_in  = {bin_ff[tcw_pkg::NUMBER_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            // keep at least one digit so zero prints as '0'
            if (top_digit == '0 && left_ff > 4'd1) begin
               bcd_in  = {bcd_ff[tcw_pkg::BCD_W-tcw_pkg::DIGIT_W-1:0], {tcw_pkg::DIGIT_W{1'b0}}};
               left_in = left_ff - 1'b1;
            end else begin
               phase_in = PH_OUT;
            end
         end
         PH_OUT: begin
            if (next) begin
               bcd_in  = {bcd_ff[tcw_pkg::BCD_W-tcw_pkg::DIGIT_W-1:0], {tcw_pkg::DIGIT_W{1'b0}}};
               left_in = left_ff - 1'b1;
               if (left_ff == 4'd1) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      left_ff <= left_in;
   end

   assign status.valid = (phase_ff == PH_OUT);
   assign status.digit = top_digit;
   assign status.last  = (left_ff == 4'd1);

endmodule

[rtl/core/text_console_writer.sv]
// Text console writer: cursor engine that turns character, number and cursor
// requests into cell writes and clear-screen responses. Depends on tcw_pkg,
// tcw_if and tcw_bcd.
//
// One request at a time. A character is accepted in S_IDLE and its cell write
// is loaded into the response register in S_PUT once that register is free;
// a write that runs off the bottom adds a clear in S_CLEAR. A newline moves
// the cursor in S_PUT and adds a clear in S_CLEAR at the bottom. Code zero,
// cursor loads and the unused action finish in the accepting cycle. A number
// runs through the shift-and-add-3 converter: it is converted bit by bit,
// its leading zeros are dropped, then each printed digit goes through S_NUM
// and S_PUT like a character, with a clear where it runs off the bottom. A
// minus sign is written while the conversion runs. Responses sit in an output
// register, so a response stall holds the engine only when the next write is
// due. The next request is taken once the final response of the previous one
// is in that register. The attribute register may be written at any idle time
// and takes effect on the next write.
module text_console_writer #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_if,
   tcw_rsp_if.source  rsp_if,
   tcw_csr_if.sink    csr_if
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PUT   = 2'd1;
   localparam logic [1:0] S_CLEAR = 2'd2;
   localparam logic [1:0] S_NUM   = 2'd3;

   localparam logic [tcw_pkg::COL_W:0] COLS_V = (tcw_pkg::COL_W+1)'(SCREEN_COLUMNS);
   localparam logic [tcw_pkg::ROW_W:0] ROWS_V = (tcw_pkg::ROW_W+1)'(SCREEN_ROWS);
   localparam logic [tcw_pkg::COL_W-1:0] COL_MAX = tcw_pkg::COL_W'(SCREEN_COLUMNS - 1);
   localparam logic [tcw_pkg::ROW_W-1:0] ROW_MAX = tcw_pkg::ROW_W'(SCREEN_ROWS - 1);
   localparam int LIN_W = tcw_pkg::COL_W + 1 + tcw_pkg::ROW_W;

   logic [1:0]                   state_ff, state_in;
   logic [tcw_pkg::COL_W-1:0]    col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tcw_pkg::ATTR_W-1:0]   attr_ff, attr_in;
   logic [tcw_pkg::CHAR_W-1:0]   ch_ff, ch_in;
   logic                         last_ff, last_in;
   logic                         num_ff, num_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [tcw_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [tcw_pkg::WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         slot_free;
   logic                         accept;
   logic [tcw_pkg::COL_W:0]      col_inc;
   logic [tcw_pkg::ROW_W:0]      row_inc;
   logic [LIN_W-1:0]             cell_lin;
   logic [1:0]                   after_put;
   logic [tcw_pkg::NUMBER_W-1:0] magnitude;
   logic                         bcd_start;
   logic                         bcd_next;
   tcw_pkg::bcd_status_type      bcd_status;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign accept    = req_if.valid && req_if.ready;
   assign col_inc   = {1'b0, col_ff} + 1'b1;
   assign row_inc   = {1'b0, row_ff} + 1'b1;
   assign cell_lin  = LIN_W'(row_ff) * LIN_W'(COLS_V) + LIN_W'(col_ff);
   assign after_put = num_ff ? S_NUM : S_IDLE;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   // 0 - x gives the right magnitude for the most negative value too
   assign magnitude = req_if.number_value[tcw_pkg::NUMBER_W-1]
                      ? 32'd0 - req_if.number_value : req_if.number_value;
   assign bcd_start = accept && req_if.action == tcw_pkg::ACT_PRINT_NUM;

   tcw_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .bin    (magnitude),
      .next   (bcd_next),
      .status (bcd_status)
   );

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = attr_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      num_in       = num_ff;
      bcd_next     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_if.valid) begin
         attr_in = csr_if.color_attribute;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_if.action)
                  tcw_pkg::ACT_PUT_CHAR: begin
                     if (req_if.char_code != tcw_pkg::CHAR_NUL) begin
                        ch_in    = req_if.char_code;
                        last_in  = 1'b1;
                        num_in   = 1'b0;
                        state_in = S_PUT;
                     end
                  end
                  tcw_pkg::ACT_PRINT_NUM: begin
                     num_in  = 1'b1;
                     if (req_if.number_value[tcw_pkg::NUMBER_W-1]) begin
                        ch_in    = tcw_pkg::CHAR_MINUS;
                        last_in  = 1'b0;
                        state_in = S_PUT;
                     end else begin
                        state_in = S_NUM;
                     end
                  end
                  tcw_pkg::ACT_SET_CURSOR: begin
                     col_in = (req_if.new_column > COL_MAX) ? COL_MAX : req_if.new_column;
                     row_in = (req_if.new_row > ROW_MAX) ? ROW_MAX : req_if.new_row;
                  end
                  default: ;
               endcase
            end
         end
         S_PUT: begin
            if (ch_ff == tcw_pkg::CHAR_LF) begin
               col_in = '0;
               row_in = row_inc[tcw_pkg::ROW_W-1:0];
               state_in = (row_inc >= ROWS_V) ? S_CLEAR : after_put;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = tcw_pkg::KIND_WRITE;
               rsp_addr_in  = cell_lin[tcw_pkg::ADDR_W-1:0];
               rsp_word_in  = {attr_ff, ch_ff};
               if (col_inc >= COLS_V) begin
                  col_in = '0;
                  row_in = row_inc[tcw_pkg::ROW_W-1:0];
                  if (row_inc >= ROWS_V) begin
                     rsp_last_in = 1'b0;
                     state_in    = S_CLEAR;
                  end else begin
                     rsp_last_in = last_ff;
                     state_in    = after_put;
                  end
               end else begin
                  col_in      = col_inc[tcw_pkg::COL_W-1:0];
                  rsp_last_in = last_ff;
                  state_in    = after_put;
               end
            end
         end
         S_CLEAR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = tcw_pkg::KIND_CLEAR;
               rsp_addr_in  = '0;
               rsp_word_in  = {attr_ff, tcw_pkg::CHAR_SPACE};
               rsp_last_in  = last_ff;
               col_in       = '0;
               row_in       = '0;
               state_in     = after_put;
            end
         end
         S_NUM: begin
            if (bcd_status.valid) begin
               bcd_next = 1'b1;
               ch_in    = tcw_pkg::CHAR_ZERO | {4'd0, bcd_status.digit};
               last_in  = bcd_status.last;
               num_in   = !bcd_status.last;
               state_in = S_PUT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         num_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_kind  = rsp_kind_ff;
   assign rsp_if.cell_address = rsp_addr_ff;
   assign rsp_if.cell_word    = rsp_word_ff;
   assign rsp_if.last_result  = rsp_last_ff;

endmodule

[verif/text_console_writer_test.sv]
`timescale 1ns / 100ps
// Testbench of text_console_writer: a directed script followed by random requests,
// every response checked against a typed-in result or a cursor and decimal-print predictor kept here.
// Needs tcw_pkg, the tcw_if interfaces and the RTL of text_console_writer.
module text_console_writer_test;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam logic [tcw_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int IDLE_LIMIT    = 1000;
   localparam int PHASE_ITEMS   = 31;
   localparam int PHASES        = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 60;
   localparam int MAX_WAIT      = 18;

   typedef struct packed {
      logic [tcw_pkg::ACTION_W-1:0] action;
      logic [tcw_pkg::CHAR_W-1:0]   char_code;
      logic [tcw_pkg::NUMBER_W-1:0] number_value;
      logic [tcw_pkg::COL_W-1:0]    new_column;
      logic [tcw_pkg::ROW_W-1:0]    new_row;
   } console_req_type;

   typedef struct packed {
      logic                       kind;
      logic [tcw_pkg::ADDR_W-1:0] addr;
      logic [tcw_pkg::WORD_W-1:0] word;
      logic                       last;
   } cell_op_type;

   // n_typed < 0: take the predictor's results; otherwise the typed-in count (0 or 1)
   typedef struct {
      console_req_type req;
      int              n_typed;
      cell_op_type     typed;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();
   tcw_csr_if csr_bus ();

   text_console_writer #(
      .SCREEN_COLUMNS(COLUMNS),
      .SCREEN_ROWS   (ROWS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   int unsigned                cur_col;
   int unsigned                cur_row;
   logic [tcw_pkg::ATTR_W-1:0] attr;

   cell_op_type    item_cells[$];
   cell_op_type    cells_due[$];
   script_row_type script[$];

   int errors      = 0;
   int idle_cycles = 0;
   int send_burst  = 0;
   int sink_burst  = 0;

   function automatic void emit_cell(logic kind, int unsigned addr,
                                     logic [tcw_pkg::CHAR_W-1:0] code);
      cell_op_type op;
      op.kind = kind;
      op.addr = tcw_pkg::ADDR_W'(addr);
      op.word = {attr, code};
      op.last = 1'b0;
      item_cells.push_back(op);
   endfunction

   function automatic void place_code(logic [tcw_pkg::CHAR_W-1:0] code);
      if (code == tcw_pkg::CHAR_NUL) return;
      if (code == tcw_pkg::CHAR_LF) begin
         cur_col = 0;
         cur_row++;
      end else begin
         emit_cell(tcw_pkg::KIND_WRITE, cur_row * COLUMNS + cur_col, code);
         cur_col++;
         if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
         end
      end
      // ran off the bottom: clear and home
      if (cur_row >= ROWS) begin
         emit_cell(tcw_pkg::KIND_CLEAR, 0, tcw_pkg::CHAR_SPACE);
         cur_col = 0;
         cur_row = 0;
      end
   endfunction

   function automatic void print_decimal(logic [tcw_pkg::NUMBER_W-1:0] raw);
      logic [tcw_pkg::NUMBER_W-1:0] mag;
      int unsigned                  digit_q[$];
      mag = raw;
      if (raw[tcw_pkg::NUMBER_W-1]) begin
         place_code(tcw_pkg::CHAR_MINUS);
         mag = -raw;   // most negative value stays 2^31 as unsigned
      end
      do begin
         digit_q.push_back(mag % 10);
         mag = mag / 10;
      end while (mag != 0);
      while (digit_q.size() > 0)
         place_code(tcw_pkg::CHAR_ZERO + tcw_pkg::CHAR_W'(digit_q.pop_back()));
   endfunction

   function automatic void console_predict(console_req_type it);
      int unsigned c;
      int unsigned r;
      item_cells.delete();
      case (it.action)
         tcw_pkg::ACT_PUT_CHAR:  place_code(it.char_code);
         tcw_pkg::ACT_PRINT_NUM: print_decimal(it.number_value);
         tcw_pkg::ACT_SET_CURSOR: begin
            c = int'(it.new_column);
            r = int'(it.new_row);
            if (c > COLUMNS - 1) c = COLUMNS - 1;
            if (r > ROWS - 1) r = ROWS - 1;
            cur_col = c;
            cur_row = r;
         end
         default: ;
      endcase
   endfunction

   function automatic bit is_ignored(console_req_type it);
      return it.action == ACT_UNUSED ||
             (it.action == tcw_pkg::ACT_PUT_CHAR && it.char_code == tcw_pkg::CHAR_NUL);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   // wait before the next transfer; runs of zero waits now and then
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void add_row(logic [tcw_pkg::ACTION_W-1:0] action,
                                   logic [tcw_pkg::CHAR_W-1:0] code,
                                   logic [tcw_pkg::NUMBER_W-1:0] number,
                                   logic [tcw_pkg::COL_W-1:0] col,
                                   logic [tcw_pkg::ROW_W-1:0] row, int n_typed, logic kind,
                                   logic [tcw_pkg::ADDR_W-1:0] addr,
                                   logic [tcw_pkg::WORD_W-1:0] word);
      script_row_type s;
      s.req.action       = action;
      s.req.char_code    = code;
      s.req.number_value = number;
      s.req.new_column   = col;
      s.req.new_row      = row;
      s.n_typed          = n_typed;
      s.typed.kind       = kind;
      s.typed.addr       = addr;
      s.typed.word       = word;
      s.typed.last       = 1'b1;
      script.push_back(s);
   endfunction

   function automatic console_req_type random_request();
      console_req_type it;
      int              pick;
      // unused fields carry noise
      it.action       = tcw_pkg::ACTION_W'($urandom);
      it.char_code    = tcw_pkg::CHAR_W'($urandom);
      it.number_value = $urandom;
      it.new_column   = tcw_pkg::COL_W'($urandom);
      it.new_row      = tcw_pkg::ROW_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         it.action = tcw_pkg::ACT_PUT_CHAR;
         case ($urandom_range(0, 19))
            0:       it.char_code = tcw_pkg::CHAR_NUL;
            1, 2, 3: it.char_code = tcw_pkg::CHAR_LF;
            default: it.char_code = tcw_pkg::CHAR_W'($urandom_range(1, 255));
         endcase
      end else if (pick < 70) begin
         it.action = tcw_pkg::ACT_PRINT_NUM;
         case ($urandom_range(0, 9))
            0:       it.number_value = 32'h8000_0000;
            1:       it.number_value = 32'h7FFF_FFFF;
            2, 3:    it.number_value = $urandom_range(0, 99);
            4, 5:    it.number_value = -$urandom_range(0, 9999);
            default: it.number_value = $urandom;
         endcase
      end else if (pick < 93) begin
         it.action = tcw_pkg::ACT_SET_CURSOR;
         case ($urandom_range(0, 9))
            0, 1:          it.new_column = tcw_pkg::COL_W'($urandom_range(COLUMNS, 127));
            2, 3, 4, 5, 6: it.new_column = tcw_pkg::COL_W'($urandom_range(COLUMNS - 20,
                                                                          COLUMNS - 1));
            default:       it.new_column = tcw_pkg::COL_W'($urandom_range(0, COLUMNS - 1));
         endcase
         case ($urandom_range(0, 9))
            0:             it.new_row = tcw_pkg::ROW_W'($urandom_range(ROWS, 31));
            1, 2, 3, 4, 5: it.new_row = tcw_pkg::ROW_W'($urandom_range(ROWS - 5, ROWS - 1));
            default:       it.new_row = tcw_pkg::ROW_W'($urandom_range(0, ROWS - 1));
         endcase
      end else begin
         it.action = ACT_UNUSED;
      end
      return it;
   endfunction

   task automatic send_request(input console_req_type it, input int n_typed,
                               input cell_op_type typed);
      int          gap;
      cell_op_type op;
      gap = draw_wait(send_burst);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= it.action;
      req_bus.char_code    <= it.char_code;
      req_bus.number_value <= it.number_value;
      req_bus.new_column   <= it.new_column;
      req_bus.new_row      <= it.new_row;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      // request transfer done: update the predictor
      console_predict(it);
      if (n_typed < 0) begin
         if (item_cells.size() > 0) begin
            op = item_cells.pop_back();
            op.last = 1'b1;
            item_cells.push_back(op);
         end
         foreach (item_cells[i]) cells_due.push_back(item_cells[i]);
      end else if (n_typed > 0) begin
         cells_due.push_back(typed);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (cells_due.size() != 0);
   endtask

   task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.color_attribute <= value;
      csr_bus.valid           <= 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      attr = value;
   endtask

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : result_sink
      int          stall;
      cell_op_type exp_op;
      cell_op_type got;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = draw_wait(sink_burst);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.kind = rsp_bus.result_kind;
         got.addr = rsp_bus.cell_address;
         got.word = rsp_bus.cell_word;
         got.last = rsp_bus.last_result;
         if (cells_due.size() == 0) begin
            report_error($sformatf("unexpected result kind %0d addr %0d word %h last %0d",
                                   got.kind, got.addr, got.word, got.last));
         end else begin
            exp_op = cells_due.pop_front();
            if (got.kind !== exp_op.kind)
               report_error($sformatf("result_kind: expected %0d, got %0d",
                                      exp_op.kind, got.kind));
            if (got.addr !== exp_op.addr)
               report_error($sformatf("cell_address: expected %0d, got %0d",
                                      exp_op.addr, got.addr));
            if (got.word !== exp_op.word)
               report_error($sformatf("cell_word: expected %h, got %h",
                                      exp_op.word, got.word));
            if (got.last !== exp_op.last)
               report_error($sformatf("last_result: expected %0d, got %0d",
                                      exp_op.last, got.last));
         end
      end
   end

   initial begin : stimulus
      logic [tcw_pkg::ATTR_W-1:0] attr_plan[PHASES];
      cell_op_type                no_op;
      console_req_type            it;
      int                         counted;

      req_bus.valid           = 1'b0;
      req_bus.action          = tcw_pkg::ACT_PUT_CHAR;
      req_bus.char_code       = tcw_pkg::CHAR_NUL;
      req_bus.number_value    = '0;
      req_bus.new_column      = '0;
      req_bus.new_row         = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.color_attribute = tcw_pkg::ATTR_RESET;
      no_op                   = '0;
      attr                    = tcw_pkg::ATTR_RESET;
      cur_col                 = 0;
      cur_row                 = 0;

      // directed script, attribute at its reset value
      add_row(tcw_pkg::ACT_PUT_CHAR,   8'h41,             '0,     '0,     '0,
              1, tcw_pkg::KIND_WRITE, 0, 16'h0F41);
      add_row(tcw_pkg::ACT_PUT_CHAR,   tcw_pkg::CHAR_NUL, '0,     '0,     '0,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PUT_CHAR,   8'hFF,             '0,     '0,     '0,
              1, tcw_pkg::KIND_WRITE, 1, 16'h0FFF);
      add_row(tcw_pkg::ACT_PUT_CHAR,   tcw_pkg::CHAR_LF,  '0,     '0,     '0,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_SET_CURSOR, '0,                '0,     7'd127, 5'd31,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PUT_CHAR,   8'h5A,             '0,     '0,     '0,
              -1, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(ACT_UNUSED,              8'h41,             32'd7,  7'd3,   5'd3,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PRINT_NUM,  '0,                32'd0,  '0,     '0,
              1, tcw_pkg::KIND_WRITE, 0, 16'h0F30);
      add_row(tcw_pkg::ACT_PRINT_NUM,  '0,                32'h8000_0000, '0, '0,
              -1, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PRINT_NUM,  '0,                32'h7FFF_FFFF, '0, '0,
              -1, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PRINT_NUM,  '0,                32'hFFFF_FFFF, '0, '0,
              -1, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_SET_CURSOR, '0,                '0,     7'd78,  5'd24,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PRINT_NUM,  '0,                32'd12345, '0,  '0,
              -1, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_SET_CURSOR, '0,                '0,     7'd0,   5'd24,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PUT_CHAR,   tcw_pkg::CHAR_LF,  '0,     '0,     '0,
              1, tcw_pkg::KIND_CLEAR, 0, 16'h0F20);
      add_row(tcw_pkg::ACT_PUT_CHAR,   8'h01,             '0,     '0,     '0,
              1, tcw_pkg::KIND_WRITE, 0, 16'h0F01);
      add_row(tcw_pkg::ACT_SET_CURSOR, '0,                '0,     7'd79,  5'd0,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PUT_CHAR,   8'h80,             '0,     '0,     '0,
              1, tcw_pkg::KIND_WRITE, 79, 16'h0F80);
      add_row(tcw_pkg::ACT_SET_CURSOR, '0,                '0,     7'd80,  5'd25,
              0, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PUT_CHAR,   tcw_pkg::CHAR_LF,  '0,     '0,     '0,
              1, tcw_pkg::KIND_CLEAR, 0, 16'h0F20);
      add_row(tcw_pkg::ACT_PUT_CHAR,   8'h7F,             '0,     '0,     '0,
              1, tcw_pkg::KIND_WRITE, 0, 16'h0F7F);
      add_row(tcw_pkg::ACT_PRINT_NUM,  '0,                -32'sd999999999, '0, '0,
              -1, tcw_pkg::KIND_WRITE, 0, 0);
      add_row(tcw_pkg::ACT_PRINT_NUM,  '0,                32'd1000000000, '0, '0,
              -1, tcw_pkg::KIND_WRITE, 0, 0);

      attr_plan[0] = 8'hFF;
      attr_plan[1] = 8'h00;
      for (int p = 2; p < PHASES - 1; p++)
         attr_plan[p] = tcw_pkg::ATTR_W'($urandom_range(1, 254));
      attr_plan[PHASES-1] = tcw_pkg::ATTR_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_request(script[i].req, script[i].n_typed, script[i].typed);

      for (int p = 0; p < PHASES; p++) begin
         write_attribute(attr_plan[p]);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if ($urandom_range(0, 29) == 0) drain_results();
            it = random_request();
            send_request(it, -1, no_op);
            if (!is_ignored(it)) counted++;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_bcd.sv
rtl/core/text_console_writer.sv
verif/text_console_writer_test.sv
